// ===== src/csr_pkg.sv =====
// ----------------------------------------------------------------------------
// csr_pkg
// Shared sizes, codes and transaction types of the CSR adjacency builder.
// ----------------------------------------------------------------------------
package csr_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 2048;
  localparam int MAX_ENTRIES  = 4096;

  localparam int VID_W  = $clog2(MAX_VERTICES);      // vertex id
  localparam int VCNT_W = VID_W + 1;                 // vertex count / offset address
  localparam int EADR_W = $clog2(MAX_EDGES);         // edge store address
  localparam int ECNT_W = EADR_W + 1;                // edge count
  localparam int AADR_W = $clog2(MAX_ENTRIES);       // adjacency address
  localparam int ENT_W  = AADR_W + 1;                // entry count / offset

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_BUILD = 3'd1;
  localparam logic [2:0] OP_DEG   = 3'd2;
  localparam logic [2:0] OP_NBR   = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NEG_ID    = 3'd1;
  localparam logic [2:0] ST_RANGE_ID  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_QV    = 3'd4;
  localparam logic [2:0] ST_BAD_INDEX = 3'd5;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_IS_DIRECTED  = 1'b1;

  // controller steps
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_Q1   = 5'd1;
  localparam logic [4:0] S_Q2   = 5'd2;
  localparam logic [4:0] S_Q3   = 5'd3;
  localparam logic [4:0] S_CLR  = 5'd4;
  localparam logic [4:0] S_CRD  = 5'd5;
  localparam logic [4:0] S_CCHK = 5'd6;
  localparam logic [4:0] S_CS1  = 5'd7;
  localparam logic [4:0] S_CD0  = 5'd8;
  localparam logic [4:0] S_CD1  = 5'd9;
  localparam logic [4:0] S_PRD  = 5'd10;
  localparam logic [4:0] S_PWR  = 5'd11;
  localparam logic [4:0] S_XRD  = 5'd12;
  localparam logic [4:0] S_XCHK = 5'd13;
  localparam logic [4:0] S_XS1  = 5'd14;
  localparam logic [4:0] S_XD0  = 5'd15;
  localparam logic [4:0] S_XD1  = 5'd16;
  localparam logic [4:0] S_V0   = 5'd17;
  localparam logic [4:0] S_V1   = 5'd18;
  localparam logic [4:0] S_V2   = 5'd19;
  localparam logic [4:0] S_SI   = 5'd20;
  localparam logic [4:0] S_SK   = 5'd21;
  localparam logic [4:0] S_SJ   = 5'd22;
  localparam logic [4:0] S_SW   = 5'd23;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [15:0] source_vertex;
    logic signed [15:0] dest_vertex;
    logic [15:0]        query_vertex;
    logic [11:0]        entry_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [12:0] list_offset;
    logic [12:0] degree_out;
    logic [9:0]  neighbor_id;
    logic [11:0] edges_held;
    logic [12:0] entries_held;
  } out_item_t;

  typedef struct packed {
    logic [4:0] step;
    logic       accept;
    logic       finish;
  } csr_cmd_t;

  typedef struct packed {
    logic qv_bad;
    logic k_bad;
    logic op_deg;
    logic edge_end;
    logic edge_ok;
    logic room;
    logic room2;
    logic undir;
    logic vi_last;
    logic vert_end;
    logic i_end;
    logic shift;
    logic j_more;
  } csr_sts_t;

endpackage

// ===== src/csr_ctrl.sv =====
// ----------------------------------------------------------------------------
// csr_ctrl
// Sequencer for appends, clears, queries and the multi-pass table build.
// ----------------------------------------------------------------------------
module csr_ctrl import csr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] op,
  input  csr_sts_t   sts,
  output csr_cmd_t   cmd,
  output logic       busy
);

  logic [4:0] state_r, state_nxt;
  logic       accept, finish;

  always_comb begin
    state_nxt = state_r;
    accept    = 1'b0;
    finish    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          accept = 1'b1;
          if (op == OP_BUILD) begin
            state_nxt = S_CLR;
          end else if (op == OP_DEG || op == OP_NBR) begin
            state_nxt = S_Q1;
          end else begin
            finish = 1'b1;
          end
        end
      end
      S_Q1: begin
        if (sts.qv_bad) begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_Q2;
        end
      end
      S_Q2: begin
        if (sts.op_deg || sts.k_bad) begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_Q3;
        end
      end
      S_Q3: begin
        finish    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLR:  if (sts.vi_last) state_nxt = S_CRD;
      S_CRD:  state_nxt = sts.edge_end ? S_PRD : S_CCHK;
      S_CCHK: state_nxt = (sts.edge_ok && sts.room) ? S_CS1 : S_CRD;
      S_CS1:  state_nxt = (sts.undir && sts.room2) ? S_CD0 : S_CRD;
      S_CD0:  state_nxt = S_CD1;
      S_CD1:  state_nxt = S_CRD;
      S_PRD:  state_nxt = S_PWR;
      S_PWR:  state_nxt = sts.vi_last ? S_XRD : S_PRD;
      S_XRD:  state_nxt = sts.edge_end ? S_V0 : S_XCHK;
      S_XCHK: state_nxt = (sts.edge_ok && sts.room) ? S_XS1 : S_XRD;
      S_XS1:  state_nxt = (sts.undir && sts.room2) ? S_XD0 : S_XRD;
      S_XD0:  state_nxt = S_XD1;
      S_XD1:  state_nxt = S_XRD;
      S_V0: begin
        if (sts.vert_end) begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_V1;
        end
      end
      S_V1:   state_nxt = S_V2;
      S_V2:   state_nxt = S_SI;
      S_SI:   state_nxt = sts.i_end ? S_V0 : S_SK;
      S_SK:   state_nxt = S_SJ;
      S_SJ: begin
        if (!sts.shift) begin
          state_nxt = S_SI;
        end else if (!sts.j_more) begin
          state_nxt = S_SW;
        end
      end
      S_SW:   state_nxt = S_SI;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.step   = state_r;
  assign cmd.accept = accept;
  assign cmd.finish = finish;
  assign busy       = (state_r != S_IDLE);

endmodule

// ===== src/csr_datapath.sv =====
// ----------------------------------------------------------------------------
// csr_datapath
// Edge, offset, fill and adjacency stores with the counters of the build.
// ----------------------------------------------------------------------------
module csr_datapath import csr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  csr_cmd_t          cmd,
  input  in_item_t          in_data,
  input  logic [VCNT_W-1:0] live_n,
  input  logic              is_directed,
  output csr_sts_t          sts,
  output logic              out_valid,
  output out_item_t         out_data
);

  logic [VID_W-1:0] src_mem [0:MAX_EDGES-1];
  logic [VID_W-1:0] dst_mem [0:MAX_EDGES-1];
  logic [ENT_W-1:0] off_mem [0:MAX_VERTICES];
  logic [ENT_W-1:0] fill_mem [0:MAX_VERTICES-1];
  logic [VID_W-1:0] adj_mem [0:MAX_ENTRIES-1];

  logic [VID_W-1:0]  src_rd, dst_rd, adj_rd;
  logic [ENT_W-1:0]  off_rd, fill_rd;

  logic [ECNT_W-1:0] edge_total_r, edge_total_nxt;
  logic [ENT_W-1:0]  entry_total_r;
  logic              built_r, skipped_r;
  logic [ECNT_W-1:0] idx_r;
  logic [VCNT_W-1:0] vi_r;
  logic [ENT_W-1:0]  used_r, acc_r, lo_r, hi_r, i_r, j_r, offset_r, deg_r;
  logic [VID_W-1:0]  key_r;
  logic [2:0]        op_r;
  logic [15:0]       qv_r;
  logic [11:0]       k_r;

  logic [ENT_W-1:0]  off_eff, deg_q, sum;
  logic [2:0]        add_status;
  logic              add_ok;
  logic [VCNT_W-1:0] off_ra, off_wa;
  logic              off_we;
  logic [ENT_W-1:0]  off_wd;
  logic [VID_W-1:0]  fill_ra, fill_wa;
  logic              fill_we;
  logic [ENT_W-1:0]  fill_wd;
  logic [AADR_W-1:0] adj_ra, adj_wa;
  logic              adj_we;
  logic [VID_W-1:0]  adj_wd;
  out_item_t         res;
  out_item_t         out_data_r;
  logic              out_valid_r;

  // status flags
  always_comb begin
    off_eff      = built_r ? off_rd : '0;
    deg_q        = off_eff - offset_r;
    sts.qv_bad   = (qv_r >= {5'b0, live_n});
    sts.k_bad    = ({1'b0, k_r} >= deg_q);
    sts.op_deg   = (op_r == OP_DEG);
    sts.edge_end = (idx_r == edge_total_r);
    sts.edge_ok  = ({1'b0, src_rd} < live_n) && ({1'b0, dst_rd} < live_n);
    sts.room     = (used_r < ENT_W'(MAX_ENTRIES));
    sts.room2    = (used_r < ENT_W'(MAX_ENTRIES - 1));
    sts.undir    = !is_directed;
    sts.vi_last  = (vi_r == VCNT_W'(MAX_VERTICES));
    sts.vert_end = (vi_r == live_n);
    sts.i_end    = (i_r >= hi_r);
    sts.shift    = (adj_rd > key_r);
    sts.j_more   = ((j_r - 1'b1) > lo_r);
  end

  always_comb begin
    add_status = ST_OK;
    if (in_data.source_vertex[15] || in_data.dest_vertex[15]) begin
      add_status = ST_NEG_ID;
    end else if (in_data.source_vertex >= $signed({5'b0, live_n}) ||
                 in_data.dest_vertex >= $signed({5'b0, live_n})) begin
      add_status = ST_RANGE_ID;
    end else if (edge_total_r >= ECNT_W'(MAX_EDGES)) begin
      add_status = ST_FULL;
    end
    add_ok = cmd.accept && (in_data.op == OP_ADD) && (add_status == ST_OK);
    edge_total_nxt = edge_total_r;
    if (add_ok) begin
      edge_total_nxt = edge_total_r + 1'b1;
    end else if (cmd.accept && in_data.op == OP_CLEAR) begin
      edge_total_nxt = '0;
    end
  end

  // memory addressing
  always_comb begin
    sum     = acc_r + off_rd;
    off_ra  = vi_r;
    off_we  = 1'b0;
    off_wa  = vi_r;
    off_wd  = '0;
    fill_ra = src_rd;
    fill_we = 1'b0;
    fill_wa = src_rd;
    fill_wd = fill_rd + 1'b1;
    adj_ra  = i_r[AADR_W-1:0];
    adj_we  = 1'b0;
    adj_wa  = fill_rd[AADR_W-1:0];
    adj_wd  = dst_rd;
    case (cmd.step)
      S_IDLE: off_ra = in_data.query_vertex[VCNT_W-1:0];
      S_Q1:   off_ra = qv_r[VCNT_W-1:0] + 1'b1;
      S_Q2:   adj_ra = AADR_W'(offset_r + {1'b0, k_r});
      S_CLR: begin
        off_we = 1'b1;
      end
      S_CCHK: off_ra = {1'b0, src_rd} + 1'b1;
      S_CS1: begin
        off_we = 1'b1;
        off_wa = {1'b0, src_rd} + 1'b1;
        off_wd = off_rd + 1'b1;
      end
      S_CD0:  off_ra = {1'b0, dst_rd} + 1'b1;
      S_CD1: begin
        off_we = 1'b1;
        off_wa = {1'b0, dst_rd} + 1'b1;
        off_wd = off_rd + 1'b1;
      end
      S_PWR: begin
        off_we  = 1'b1;
        off_wd  = sum;
        fill_we = 1'b1;
        fill_wa = VID_W'(vi_r - 1'b1);
        fill_wd = acc_r;
      end
      S_XCHK: fill_ra = src_rd;
      S_XS1: begin
        fill_we = 1'b1;
        adj_we  = 1'b1;
      end
      S_XD0:  fill_ra = dst_rd;
      S_XD1: begin
        fill_we = 1'b1;
        fill_wa = dst_rd;
        adj_we  = 1'b1;
        adj_wd  = src_rd;
      end
      S_V1:   off_ra = vi_r + 1'b1;
      S_SK:   adj_ra = AADR_W'(i_r - 1'b1);
      S_SJ: begin
        adj_ra = AADR_W'(j_r - 2'd2);
        adj_we = 1'b1;
        adj_wa = j_r[AADR_W-1:0];
        adj_wd = sts.shift ? adj_rd : key_r;
      end
      S_SW: begin
        adj_we = 1'b1;
        adj_wa = j_r[AADR_W-1:0];
        adj_wd = key_r;
      end
      default: off_ra = vi_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (add_ok) begin
      src_mem[edge_total_r[EADR_W-1:0]] <= in_data.source_vertex[VID_W-1:0];
      dst_mem[edge_total_r[EADR_W-1:0]] <= in_data.dest_vertex[VID_W-1:0];
    end
    src_rd <= src_mem[idx_r[EADR_W-1:0]];
    dst_rd <= dst_mem[idx_r[EADR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[off_wa] <= off_wd;
    end
    off_rd <= off_mem[off_ra];
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    fill_rd <= fill_mem[fill_ra];
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    adj_rd <= adj_mem[adj_ra];
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_total_r  <= '0;
      entry_total_r <= '0;
      built_r       <= 1'b0;
      skipped_r     <= 1'b0;
      idx_r         <= '0;
      vi_r          <= '0;
      used_r        <= '0;
      acc_r         <= '0;
    end else begin
      edge_total_r <= edge_total_nxt;
      case (cmd.step)
        S_IDLE: begin
          if (cmd.accept) begin
            idx_r     <= '0;
            vi_r      <= '0;
            used_r    <= '0;
            skipped_r <= 1'b0;
          end
        end
        S_CLR: begin
          built_r <= 1'b1;
          acc_r   <= '0;
          vi_r    <= sts.vi_last ? VCNT_W'(1) : vi_r + 1'b1;
        end
        S_CCHK, S_XCHK: begin
          if (!sts.edge_ok) begin
            skipped_r <= 1'b1;
            idx_r     <= idx_r + 1'b1;
          end else if (!sts.room) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_CS1, S_XS1: begin
          used_r <= used_r + 1'b1;
          if (!(sts.undir && sts.room2)) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_CD1, S_XD1: begin
          used_r <= used_r + 1'b1;
          idx_r  <= idx_r + 1'b1;
        end
        S_PWR: begin
          acc_r <= sum;
          if (sts.vi_last) begin
            entry_total_r <= sum;
            idx_r         <= '0;
            used_r        <= '0;
            vi_r          <= '0;
          end else begin
            vi_r <= vi_r + 1'b1;
          end
        end
        S_SI: begin
          if (sts.i_end) begin
            vi_r <= vi_r + 1'b1;
          end
        end
        default: vi_r <= vi_r;
      endcase
    end
  end

  // query and sort registers
  always_ff @(posedge clk) begin
    case (cmd.step)
      S_IDLE: begin
        op_r <= in_data.op;
        qv_r <= in_data.query_vertex;
        k_r  <= in_data.entry_index;
      end
      S_Q1: offset_r <= off_eff;
      S_Q2: deg_r    <= deg_q;
      S_V1: lo_r     <= off_rd;
      S_V2: begin
        hi_r <= off_rd;
        i_r  <= lo_r + 1'b1;
      end
      S_SK: begin
        key_r <= adj_rd;
        j_r   <= i_r;
      end
      S_SJ: begin
        if (sts.shift) begin
          j_r <= j_r - 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      S_SW: i_r <= i_r + 1'b1;
      default: key_r <= key_r;
    endcase
  end

  // result
  always_comb begin
    res              = '0;
    res.edges_held   = edge_total_nxt;
    res.entries_held = entry_total_r;
    case (cmd.step)
      S_IDLE: res.status = (in_data.op == OP_ADD) ? add_status : ST_OK;
      S_Q1:   res.status = ST_BAD_QV;
      S_Q2: begin
        res.status      = sts.op_deg ? ST_OK : ST_BAD_INDEX;
        res.list_offset = offset_r;
        res.degree_out  = deg_q;
      end
      S_Q3: begin
        res.list_offset = offset_r;
        res.degree_out  = deg_r;
        res.neighbor_id = adj_rd;
      end
      S_V0:   res.status = skipped_r ? ST_RANGE_ID : ST_OK;
      default: res.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/csr_adjacency_builder.sv =====
// ----------------------------------------------------------------------------
// csr_adjacency_builder
// Builds a compressed sparse row adjacency table from a stored edge list.
//
//   channel  ports                         handshake
//   input    start, busy, in_data          taken when start && !busy
//   result   out_valid, out_data           one-cycle strobe, no backpressure
//   config   psel/penable/pwrite/paddr     write in access phase, pready high
//
// add edge, clear and unknown ops finish in the cycle they are taken; the
// result strobe follows in the next. degree query steps through Q1 and Q2,
// neighbor query on through Q3. build is set by the offset, edge and
// adjacency memory ports: it clears offsets, counts edges per vertex,
// takes the prefix sum, scatters edges into the adjacency store, then
// insertion-sorts each vertex's list.
// reset clears the control state and empties the offset table; no pass
// over memory is needed. busy stays high until the result strobe.
// ----------------------------------------------------------------------------
module csr_adjacency_builder import csr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [VCNT_W-1:0] vertex_count_r;
  logic              is_directed_r;
  logic [VCNT_W-1:0] live_n;
  logic              cfg_we;
  csr_cmd_t          cmd;
  csr_sts_t          sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCNT_W'(MAX_VERTICES);
      is_directed_r  <= 1'b0;
    end else if (cfg_we) begin
      if (paddr[2] == REG_VERTEX_COUNT) begin
        vertex_count_r <= pwdata[VCNT_W-1:0];
      end else begin
        is_directed_r <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_IS_DIRECTED) ? {31'b0, is_directed_r}
                                                 : {{(32-VCNT_W){1'b0}}, vertex_count_r};

  assign live_n = (vertex_count_r > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES)
                                                           : vertex_count_r;

  csr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_data.op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  csr_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .live_n      (live_n),
    .is_directed (is_directed_r),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

// ===== tb/tb_csr_adjacency_builder.sv =====
// ----------------------------------------------------------------------------
// tb_csr_adjacency_builder
// Self-checking bench for the CSR adjacency builder. Edge appends, builds,
// degree and neighbor queries and clears are driven through the command
// port with random gaps. Vertex count and direction are changed over the
// APB port between phases. A scoreboard keeps its own edge list and CSR
// table and checks every result strobe field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_csr_adjacency_builder;
  import csr_pkg::*;

  class csr_scoreboard;
    int unsigned vcount;
    bit          directed;
    bit [9:0]    edge_src[MAX_EDGES];
    bit [9:0]    edge_dst[MAX_EDGES];
    int          edge_cnt;
    int          offsets[MAX_VERTICES + 1];
    bit [9:0]    adj[MAX_ENTRIES];
    int          entry_cnt;
    bit [9:0]    lists[MAX_VERTICES][$];
    out_item_t   expected_q[$];
    int          fails;
    int          checked;

    function new();
      vcount    = 1024;
      directed  = 1'b0;
      edge_cnt  = 0;
      entry_cnt = 0;
      fails     = 0;
      checked   = 0;
      foreach (offsets[i]) offsets[i] = 0;
    endfunction

    function int live();
      return (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
    endfunction

    function int degree_of(int v);
      return offsets[v + 1] - offsets[v];
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fails++;
    endtask

    // returns 1 when stale edges were skipped
    function bit rebuild();
      int n;
      int used;
      int p;
      bit skipped;
      n = live();
      used = 0;
      skipped = 1'b0;
      foreach (lists[v]) lists[v].delete();
      for (int e = 0; e < edge_cnt; e++) begin
        if (edge_src[e] >= n || edge_dst[e] >= n) begin
          skipped = 1'b1;
          continue;
        end
        if (used < MAX_ENTRIES) begin
          lists[edge_src[e]].push_back(edge_dst[e]);
          used++;
        end
        if (!directed && used < MAX_ENTRIES) begin
          lists[edge_dst[e]].push_back(edge_src[e]);
          used++;
        end
      end
      offsets[0] = 0;
      p = 0;
      for (int v = 0; v < MAX_VERTICES; v++) begin
        lists[v].sort();
        foreach (lists[v][i]) begin
          adj[p] = lists[v][i];
          p++;
        end
        offsets[v + 1] = p;
      end
      entry_cnt = p;
      return skipped;
    endfunction

    function void note(in_item_t it);
      out_item_t   r;
      int          n;
      logic [15:0] s;
      logic [15:0] d;
      n = live();
      s = it.source_vertex;
      d = it.dest_vertex;
      r = '0;
      case (it.op)
        OP_ADD: begin
          if (s[15] || d[15]) r.status = ST_NEG_ID;
          else if (s >= n || d >= n) r.status = ST_RANGE_ID;
          else if (edge_cnt >= MAX_EDGES) r.status = ST_FULL;
          else begin
            edge_src[edge_cnt] = s[9:0];
            edge_dst[edge_cnt] = d[9:0];
            edge_cnt++;
          end
        end
        OP_BUILD: r.status = rebuild() ? ST_RANGE_ID : ST_OK;
        OP_DEG, OP_NBR: begin
          if (it.query_vertex >= n) r.status = ST_BAD_QV;
          else begin
            r.list_offset = 13'(offsets[it.query_vertex]);
            r.degree_out  = 13'(degree_of(it.query_vertex));
            if (it.op == OP_NBR) begin
              if (it.entry_index >= degree_of(it.query_vertex)) r.status = ST_BAD_INDEX;
              else r.neighbor_id = adj[offsets[it.query_vertex] + it.entry_index];
            end
          end
        end
        OP_CLEAR: edge_cnt = 0;
        default: ;
      endcase
      r.edges_held   = 12'(edge_cnt);
      r.entries_held = 13'(entry_cnt);
      expected_q.push_back(r);
    endfunction

    task cmp_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report("result strobe with no transaction outstanding");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      cmp_field("status", got.status, want.status);
      cmp_field("list_offset", got.list_offset, want.list_offset);
      cmp_field("degree_out", got.degree_out, want.degree_out);
      cmp_field("neighbor_id", got.neighbor_id, want.neighbor_id);
      cmp_field("edges_held", got.edges_held, want.edges_held);
      cmp_field("entries_held", got.entries_held, want.entries_held);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  csr_scoreboard sb;
  int sent;
  int builds;
  int phases;

  csr_adjacency_builder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout waiting for the block");
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note(in_data);
    if (rst_n && out_valid) sb.check(out_data);
  end

  function automatic in_item_t mk(logic [2:0] op, int s, int d, int q, int k);
    in_item_t it;
    it.op            = op;
    it.source_vertex = 16'(s);
    it.dest_vertex   = 16'(d);
    it.query_vertex  = 16'(q);
    it.entry_index   = 12'(k);
    return it;
  endfunction

  task automatic send(in_item_t it);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sent++;
    if (it.op == OP_BUILD) builds++;
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start   <= 1'b0;
      in_data <= mk(3'($urandom_range(7)), $urandom, $urandom, $urandom, $urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int gap_len(bit quiet);
    int r;
    r = $urandom_range(99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic reg_sel, int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    if (reg_sel == REG_VERTEX_COUNT) sb.vcount = value & 32'h7ff;
    else sb.directed = value[0];
  endtask

  task automatic set_graph(int vc, bit dir);
    wait_idle();
    cfg_write(REG_VERTEX_COUNT, vc);
    cfg_write(REG_IS_DIRECTED, dir);
  endtask

  function automatic in_item_t rand_edge();
    int n;
    int r;
    n = sb.live();
    r = $urandom_range(99);
    if (n == 0 || r < 8) return mk(OP_ADD, $urandom, $urandom, $urandom, $urandom);
    if (r < 12) return mk(OP_ADD, -$urandom_range(32768, 1), $urandom_range(n - 1), 0, 0);
    if (r < 16) return mk(OP_ADD, $urandom_range(n - 1), $urandom_range(32767, n), 0, 0);
    return mk(OP_ADD, $urandom_range(n - 1), $urandom_range(n - 1), $urandom, $urandom);
  endfunction

  function automatic in_item_t rand_query();
    int n;
    int v;
    int dg;
    int r;
    n = sb.live();
    r = $urandom_range(99);
    if (n == 0 || r < 10) begin
      return mk(OP_DEG + 3'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
    end
    v = $urandom_range(n - 1);
    dg = sb.degree_of(v);
    if (r < 35) return mk(OP_DEG, $urandom, $urandom, v, $urandom);
    if (r < 45 || dg == 0) return mk(OP_NBR, $urandom, $urandom, v, $urandom);
    if (r < 50) return mk(OP_NBR, 0, 0, v, dg);
    return mk(OP_NBR, $urandom, $urandom, v, $urandom_range(dg - 1));
  endfunction

  initial begin
    int vc;
    int m;
    bit quiet;
    sb = new();
    sent = 0;
    builds = 0;
    phases = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed checks: queries before any build, rejects, self loops
    send(mk(OP_DEG, 0, 0, 1023, 0));
    send(mk(OP_NBR, 0, 0, 0, 0));
    set_graph(8, 1'b0);
    send(mk(OP_ADD, 0, 7, 0, 0));
    send(mk(OP_ADD, 7, 0, 0, 0));
    send(mk(OP_ADD, -1, 3, 0, 0));
    send(mk(OP_ADD, 3, -32768, 0, 0));
    send(mk(OP_ADD, 8, 2, 0, 0));
    send(mk(OP_ADD, 32767, 1, 0, 0));
    send(mk(OP_ADD, -1, 9, 0, 0));
    send(mk(OP_ADD, 5, 5, 0, 0));
    send(mk(OP_ADD, 5, 5, 0, 0));
    send(mk(OP_ADD, 5, 1, 0, 0));
    send(mk(OP_BUILD, 0, 0, 0, 0));
    send(mk(OP_DEG, 0, 0, 0, 0));
    send(mk(OP_DEG, 0, 0, 8, 0));
    send(mk(OP_DEG, 0, 0, 65535, 0));
    send(mk(OP_NBR, 0, 0, 5, 0));
    send(mk(OP_NBR, 0, 0, 5, 2));
    send(mk(OP_NBR, 0, 0, 5, 4095));
    send(mk(3'd5, 1, 1, 1, 1));
    send(mk(3'd6, 0, 0, 0, 0));
    send(mk(3'd7, -1, -1, 65535, 4095));
    // shrinking the graph leaves stale edges behind
    set_graph(6, 1'b1);
    send(mk(OP_BUILD, 0, 0, 0, 0));
    send(mk(OP_DEG, 0, 0, 5, 0));
    set_graph(1024, 1'b0);
    send(mk(OP_DEG, 0, 0, 1000, 0));
    send(mk(OP_CLEAR, 0, 0, 0, 0));
    send(mk(OP_BUILD, 0, 0, 0, 0));
    set_graph(0, 1'b0);
    send(mk(OP_ADD, 0, 0, 0, 0));
    send(mk(OP_DEG, 0, 0, 0, 0));

    // fill the edge store to the limit
    set_graph(1024, $urandom_range(1));
    for (int i = 0; i < MAX_EDGES + 2; i++) begin
      send(mk(OP_ADD, $urandom_range(1023), $urandom_range(1023), 0, 0));
      pause(gap_len(1'b1));
    end
    send(mk(OP_ADD, -5, 3, 0, 0));
    send(mk(OP_ADD, 1024, 3, 0, 0));
    send(mk(OP_BUILD, 0, 0, 0, 0));
    for (int i = 0; i < 20; i++) begin
      send(rand_query());
      pause(gap_len(1'b0));
    end
    send(mk(OP_CLEAR, 0, 0, 0, 0));

    // random phases
    while (phases < 8 || sent < 1600) begin
      phases++;
      case ($urandom_range(7))
        0: vc = 0;
        1: vc = 1;
        2: vc = 2;
        3: vc = 1024;
        4: vc = $urandom_range(2047, 1025);
        default: vc = $urandom_range(40, 3);
      endcase
      set_graph(vc, $urandom_range(1));
      quiet = ($urandom_range(3) == 0);
      if ($urandom_range(9) < 7) send(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
      m = $urandom_range(60);
      for (int i = 0; i < m; i++) begin
        send(rand_edge());
        pause(gap_len(quiet));
      end
      if ($urandom_range(9) == 0) send(mk(3'($urandom_range(7, 5)), $urandom, $urandom,
                                           $urandom, $urandom));
      if ($urandom_range(9) == 0) begin
        wait_idle();
        cfg_write(REG_VERTEX_COUNT, $urandom_range(40));
      end
      send(mk(OP_BUILD, $urandom, $urandom, $urandom, $urandom));
      m = $urandom_range(30, 5);
      for (int i = 0; i < m; i++) begin
        pause(gap_len(quiet));
        send(rand_query());
      end
      pause(gap_len(quiet));
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.expected_q.size() != 0) sb.report("results still outstanding at end of run");
    $display("run covered %0d transactions (%0d builds) over %0d config phases",
             sent, builds, phases);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.fails);
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
